// ----- hw/rtl/sbst_pkg.sv -----
// Shared constants and control types for the segment/box slab test pipeline.
`timescale 1ns / 1ps
package sbst_pkg;
  localparam int COORD_BITS = 32;               // default coordinate width
  localparam int N_AXES     = 3;
  localparam int N_LANES    = 2 * N_AXES;       // lane 2a: min face, 2a+1: max face
  localparam int Q_BITS     = 31;               // unsigned quotient bits (Q1.30)
  localparam int T_BITS     = 32;               // signed Q2.30 parameter
  localparam logic signed [T_BITS-1:0] T_ZERO = '0;
  localparam logic signed [T_BITS-1:0] T_ONE  = 32'sh4000_0000;
  localparam logic signed [T_BITS-1:0] T_MAX  = 32'sh7fff_ffff;
  localparam logic signed [T_BITS-1:0] T_MIN  = 32'sh8000_0000;

  // per-request control that rides beside the lane data
  typedef struct packed {
    logic              valid;
    logic [N_AXES-1:0] dz;    // direction is zero on that axis
    logic              zok;   // every zero-direction axis holds the start point
  } sbst_ctl_t;
endpackage

// ----- hw/rtl/sbst_prep.sv -----
// Front end: face differences, magnitudes and signs, two register stages.
`timescale 1ns / 1ps
module sbst_prep import sbst_pkg::*; #(
  parameter int CB = COORD_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [N_AXES-1:0][CB-1:0]        box_min,
  input  logic [N_AXES-1:0][CB-1:0]        box_max,
  input  logic [N_AXES-1:0][CB-1:0]        start,
  input  logic [N_AXES-1:0][CB-1:0]        dir,
  output logic [N_LANES-1:0][CB:0]         an,
  output logic [N_LANES-1:0][CB-1:0]       ad,
  output logic [N_LANES-1:0]               neg,
  output sbst_ctl_t                        ctl
);
  logic [N_LANES-1:0][CB:0]   num_r, num_nxt;
  logic [N_AXES-1:0][CB-1:0]  dmag_r, dmag_nxt;
  logic [N_AXES-1:0]          dneg_r;
  sbst_ctl_t                  ctla_r, ctla_nxt;
  logic [N_LANES-1:0][CB:0]   an_r, an_nxt;
  logic [N_LANES-1:0][CB-1:0] ad_r;
  logic [N_LANES-1:0]         neg_r, neg_nxt;
  sbst_ctl_t                  ctlb_r;

  // stage A
  always_comb begin
    logic zok;
    zok = 1'b1;
    for (int a = 0; a < N_AXES; a++) begin
      num_nxt[2*a]   = {box_min[a][CB-1], box_min[a]} - {start[a][CB-1], start[a]};
      num_nxt[2*a+1] = {box_max[a][CB-1], box_max[a]} - {start[a][CB-1], start[a]};
      dmag_nxt[a]    = dir[a][CB-1] ? (~dir[a] + 1'b1) : dir[a];
      ctla_nxt.dz[a] = (dir[a] == '0);
      if (ctla_nxt.dz[a] && (($signed(start[a]) < $signed(box_min[a])) ||
                             ($signed(start[a]) > $signed(box_max[a])))) begin
        zok = 1'b0;
      end
    end
    ctla_nxt.zok   = zok;
    ctla_nxt.valid = in_valid;
  end

  // stage B
  always_comb begin
    for (int l = 0; l < N_LANES; l++) begin
      an_nxt[l]  = num_r[l][CB] ? (~num_r[l] + 1'b1) : num_r[l];
      neg_nxt[l] = (num_r[l] != '0) && (num_r[l][CB] != dneg_r[l/2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctla_r.valid <= 1'b0;
      ctlb_r.valid <= 1'b0;
    end else if (en) begin
      ctla_r.valid <= ctla_nxt.valid;
      ctlb_r.valid <= ctla_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r       <= num_nxt;
      dmag_r      <= dmag_nxt;
      for (int a = 0; a < N_AXES; a++) dneg_r[a] <= dir[a][CB-1];
      ctla_r.dz   <= ctla_nxt.dz;
      ctla_r.zok  <= ctla_nxt.zok;
      an_r        <= an_nxt;
      neg_r       <= neg_nxt;
      for (int l = 0; l < N_LANES; l++) ad_r[l] <= dmag_r[l/2];
      ctlb_r.dz   <= ctla_r.dz;
      ctlb_r.zok  <= ctla_r.zok;
    end
  end

  assign an  = an_r;
  assign ad  = ad_r;
  assign neg = neg_r;
  assign ctl = ctlb_r;
endmodule

// ----- hw/rtl/sbst_div_step.sv -----
// One restoring-division stage: one quotient bit for all six lanes.
`timescale 1ns / 1ps
module sbst_div_step import sbst_pkg::*; #(
  parameter int CB  = COORD_BITS,
  parameter int BIT = Q_BITS - 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic [N_LANES-1:0][CB:0]    r_in,
  input  logic [N_LANES-1:0][CB-1:0]  ad_in,
  input  logic [N_LANES-1:0][Q_BITS-1:0] q_in,
  input  logic [N_LANES-1:0]          neg_in,
  input  logic [N_LANES-1:0]          sat_in,
  input  sbst_ctl_t                   ctl_in,
  output logic [N_LANES-1:0][CB:0]    r_out,
  output logic [N_LANES-1:0][CB-1:0]  ad_out,
  output logic [N_LANES-1:0][Q_BITS-1:0] q_out,
  output logic [N_LANES-1:0]          neg_out,
  output logic [N_LANES-1:0]          sat_out,
  output sbst_ctl_t                   ctl_out
);
  logic [N_LANES-1:0][CB:0]         r_nxt;
  logic [N_LANES-1:0][Q_BITS-1:0]   q_nxt;
  logic [N_LANES-1:0]               sat_nxt;
  logic [N_LANES-1:0][CB:0]         r_r;
  logic [N_LANES-1:0][CB-1:0]       ad_r;
  logic [N_LANES-1:0][Q_BITS-1:0]   q_r;
  logic [N_LANES-1:0]               neg_r, sat_r;
  sbst_ctl_t                        ctl_r;

  always_comb begin
    logic [CB:0] rs;
    logic        ge;
    for (int l = 0; l < N_LANES; l++) begin
      // top stage starts from the magnitude, later ones shift the remainder
      rs = (BIT == Q_BITS - 1) ? r_in[l] : {r_in[l][CB-1:0], 1'b0};
      ge = (rs >= {1'b0, ad_in[l]});
      r_nxt[l]      = ge ? (rs - {1'b0, ad_in[l]}) : rs;
      q_nxt[l]      = q_in[l];
      q_nxt[l][BIT] = ge;
      // quotient at or past 2.0 saturates
      sat_nxt[l] = (BIT == Q_BITS - 1) ? (r_in[l] >= {ad_in[l], 1'b0}) : sat_in[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r.valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r       <= r_nxt;
      ad_r      <= ad_in;
      q_r       <= q_nxt;
      neg_r     <= neg_in;
      sat_r     <= sat_nxt;
      ctl_r.dz  <= ctl_in.dz;
      ctl_r.zok <= ctl_in.zok;
    end
  end

  assign r_out   = r_r;
  assign ad_out  = ad_r;
  assign q_out   = q_r;
  assign neg_out = neg_r;
  assign sat_out = sat_r;
  assign ctl_out = ctl_r;
endmodule

// ----- hw/rtl/sbst_merge.sv -----
// Back end: signed Q2.30 parameters, slab ordering, interval reduction, result.
`timescale 1ns / 1ps
module sbst_merge import sbst_pkg::*; #(
  parameter int CB = COORD_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic [N_LANES-1:0][CB:0]       rem,
  input  logic [N_LANES-1:0][Q_BITS-1:0] q,
  input  logic [N_LANES-1:0]             neg,
  input  logic [N_LANES-1:0]             sat,
  input  sbst_ctl_t                      ctl,
  output logic                           out_valid,
  output logic                           hit
);
  logic [N_LANES-1:0][T_BITS-1:0] t_r, t_nxt;
  sbst_ctl_t                      c1_r, c2_r, c3_r, c4_r;
  logic [N_AXES-1:0][T_BITS-1:0]  lo_r, hi_r, lo_nxt, hi_nxt;
  logic [T_BITS-1:0]              mxa_r, mxb_r, mna_r, mnb_r;
  logic [T_BITS-1:0]              mx_r, mn_r;
  logic                           v5_r, hit_r;

  // stage 1: floor(-x) = ~x when inexact, -x when exact
  always_comb begin
    for (int l = 0; l < N_LANES; l++) begin
      if (sat[l])      t_nxt[l] = neg[l] ? T_MIN : T_MAX;
      else if (neg[l]) t_nxt[l] = (rem[l] != '0) ? ~{1'b0, q[l]} : (~{1'b0, q[l]} + 1'b1);
      else             t_nxt[l] = {1'b0, q[l]};
    end
  end

  // stage 2: order entry/exit per axis; zero-direction axes leave [0,1] alone
  always_comb begin
    for (int a = 0; a < N_AXES; a++) begin
      if (c1_r.dz[a]) begin
        lo_nxt[a] = T_ZERO;
        hi_nxt[a] = T_ONE;
      end else if ($signed(t_r[2*a]) > $signed(t_r[2*a+1])) begin
        lo_nxt[a] = t_r[2*a+1];
        hi_nxt[a] = t_r[2*a];
      end else begin
        lo_nxt[a] = t_r[2*a];
        hi_nxt[a] = t_r[2*a+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r.valid <= 1'b0;
      c2_r.valid <= 1'b0;
      c3_r.valid <= 1'b0;
      c4_r.valid <= 1'b0;
      v5_r       <= 1'b0;
    end else if (en) begin
      c1_r.valid <= ctl.valid;
      c2_r.valid <= c1_r.valid;
      c3_r.valid <= c2_r.valid;
      c4_r.valid <= c3_r.valid;
      v5_r       <= c4_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r      <= t_nxt;
      c1_r.dz  <= ctl.dz;
      c1_r.zok <= ctl.zok;
      lo_r     <= lo_nxt;
      hi_r     <= hi_nxt;
      c2_r.dz  <= c1_r.dz;
      c2_r.zok <= c1_r.zok;
      // stage 3: first level of the max/min trees
      mxa_r    <= ($signed(lo_r[0]) > $signed(lo_r[1])) ? lo_r[0] : lo_r[1];
      mxb_r    <= ($signed(lo_r[2]) > $signed(T_ZERO))  ? lo_r[2] : T_ZERO;
      mna_r    <= ($signed(hi_r[0]) < $signed(hi_r[1])) ? hi_r[0] : hi_r[1];
      mnb_r    <= ($signed(hi_r[2]) < $signed(T_ONE))   ? hi_r[2] : T_ONE;
      c3_r.dz  <= c2_r.dz;
      c3_r.zok <= c2_r.zok;
      // stage 4
      mx_r     <= ($signed(mxa_r) > $signed(mxb_r)) ? mxa_r : mxb_r;
      mn_r     <= ($signed(mna_r) < $signed(mnb_r)) ? mna_r : mnb_r;
      c4_r.dz  <= c3_r.dz;
      c4_r.zok <= c3_r.zok;
      // stage 5: touching counts
      hit_r    <= c4_r.zok && ($signed(mx_r) <= $signed(mn_r));
    end
  end

  assign out_valid = v5_r;
  assign hit       = hit_r;
endmodule

// ----- hw/rtl/segment_box_slab_test.sv -----
// Top level: pipelined segment versus axis-aligned box slab test.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | in_tdata: 12 coords, COORD_BITS each
//  out_    | out | out_tvalid/out_tready| out_tdata[0]: hit
//
// One request per cycle unless the output stalls; 2 front stages, 31 divider
// stages (one quotient bit each, six lanes side by side), 5 back stages.
// The divider chain is the deepest part of the pipe.
// rst_n is synchronous, active low; it clears the valid bits only.
// A stalled result freezes every stage; in_tready follows the output register.
`timescale 1ns / 1ps
module segment_box_slab_test import sbst_pkg::*; #(
  parameter int COORD_W = COORD_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // box_min_x,y,z, box_max_x,y,z, start_x,y,z, dir_x,y,z (low bits first)
  input  logic [((12*COORD_W+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // hit, then zero fill
  output logic [7:0] out_tdata
);
  localparam int CB = COORD_W;

  logic en;
  logic [N_AXES-1:0][CB-1:0] bmin, bmax, st, dr;

  logic [N_LANES-1:0][CB:0]    p_an;
  logic [N_LANES-1:0][CB-1:0]  p_ad;
  logic [N_LANES-1:0]          p_neg;
  sbst_ctl_t                   p_ctl;

  logic [Q_BITS:0][N_LANES-1:0][CB:0]         d_r;
  logic [Q_BITS:0][N_LANES-1:0][CB-1:0]       d_ad;
  logic [Q_BITS:0][N_LANES-1:0][Q_BITS-1:0]   d_q;
  logic [Q_BITS:0][N_LANES-1:0]               d_neg, d_sat;
  sbst_ctl_t [Q_BITS:0]                       d_ctl;

  logic hit;

  // whole pipe advances unless a finished result is waiting
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_comb begin
    for (int a = 0; a < N_AXES; a++) begin
      bmin[a] = in_tdata[(a)*CB +: CB];
      bmax[a] = in_tdata[(3+a)*CB +: CB];
      st[a]   = in_tdata[(6+a)*CB +: CB];
      dr[a]   = in_tdata[(9+a)*CB +: CB];
    end
  end

  sbst_prep #(.CB(CB)) u_prep (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_tvalid),
    .box_min(bmin), .box_max(bmax), .start(st), .dir(dr),
    .an(p_an), .ad(p_ad), .neg(p_neg), .ctl(p_ctl)
  );

  assign d_r[0]   = p_an;
  assign d_ad[0]  = p_ad;
  assign d_q[0]   = '0;
  assign d_neg[0] = p_neg;
  assign d_sat[0] = '0;
  assign d_ctl[0] = p_ctl;

  for (genvar k = 0; k < Q_BITS; k++) begin : g_div
    sbst_div_step #(.CB(CB), .BIT(Q_BITS - 1 - k)) u_step (
      .clk(clk), .rst_n(rst_n), .en(en),
      .r_in(d_r[k]), .ad_in(d_ad[k]), .q_in(d_q[k]),
      .neg_in(d_neg[k]), .sat_in(d_sat[k]), .ctl_in(d_ctl[k]),
      .r_out(d_r[k+1]), .ad_out(d_ad[k+1]), .q_out(d_q[k+1]),
      .neg_out(d_neg[k+1]), .sat_out(d_sat[k+1]), .ctl_out(d_ctl[k+1])
    );
  end

  sbst_merge #(.CB(CB)) u_merge (
    .clk(clk), .rst_n(rst_n), .en(en),
    .rem(d_r[Q_BITS]), .q(d_q[Q_BITS]), .neg(d_neg[Q_BITS]),
    .sat(d_sat[Q_BITS]), .ctl(d_ctl[Q_BITS]),
    .out_valid(out_tvalid), .hit(hit)
  );

  assign out_tdata = {7'd0, hit};

  // an accepted request reaches the divider input once the pipe moves again
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 in_tready |=> p_ctl.valid)
    else $error("accepted request missing at divider input");

  // a stall freezes the divider chain
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> $stable(d_ctl[Q_BITS]) && $stable(d_q[Q_BITS]))
    else $error("divider moved during stall");

  // a result can only appear on a cycle the pipe advanced
  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tready))
    else $error("result appeared without pipe advance");
endmodule
